// ===== rtl/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// Types and codes shared by the cursor sequence buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

    localparam int OP_W  = 3;
    localparam int ERR_W = 3;
    localparam int CUR_W = 8;
    localparam int LEN_W = 7;

    // Output beat layout, from the lowest bit up.
    localparam int OUT_CUR_LSB   = 0;
    localparam int OUT_START_BIT = OUT_CUR_LSB + CUR_W;
    localparam int OUT_STOP_BIT  = OUT_START_BIT + 1;
    localparam int OUT_LEN_LSB   = OUT_STOP_BIT + 1;
    localparam int OUT_ERR_LSB   = OUT_LEN_LSB + LEN_W;
    localparam int OUT_USED_W    = OUT_ERR_LSB + ERR_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_REWIND    = 3'd0,
        OP_STEP      = 3'd1,
        OP_INS_LEFT  = 3'd2,
        OP_INS_RIGHT = 3'd3,
        OP_ERASE     = 3'd4,
        OP_READ      = 3'd5
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_STEP      = 3'd1,
        ERR_FULL      = 3'd2,
        ERR_ERASE     = 3'd3,
        ERR_INS_RIGHT = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_PUT,
        ST_FETCH,
        ST_CAPTURE
    } t_state;

    typedef struct packed {
        logic load;
        logic pos_zero;
        logic pos_inc;
        logic err_we;
        t_err err;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic count_dec;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic past_end;
        logic shift_more;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/csb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csb_ctrl
// Command sequencer: checks each command, steps the element moves one at a
// time and hands the final cursor read to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_ctrl
    import csb_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (i_sts.op)
                    OP_INS_LEFT: begin
                        n_state = i_sts.full ? ST_FETCH : ST_SHIFT;
                    end
                    OP_INS_RIGHT: begin
                        if (i_sts.full || (!i_sts.empty && i_sts.past_end)) begin
                            n_state = ST_FETCH;
                        end else begin
                            n_state = ST_SHIFT;
                        end
                    end
                    OP_ERASE: begin
                        n_state = i_sts.past_end ? ST_FETCH : ST_SHIFT;
                    end
                    default: begin
                        n_state = ST_FETCH;
                    end
                endcase
            end
            ST_SHIFT: begin
                if (i_sts.shift_more) begin
                    n_state = ST_SHIFT_WR;
                end else if (i_sts.op == OP_ERASE) begin
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_SHIFT_WR: n_state = ST_SHIFT;
            ST_PUT:      n_state = ST_FETCH;
            ST_FETCH:    n_state = ST_CAPTURE;
            ST_CAPTURE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.err  = ERR_OK;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_DECIDE: begin
                case (i_sts.op)
                    OP_REWIND: o_cmd.pos_zero = 1'b1;
                    OP_STEP: begin
                        if (i_sts.past_end) begin
                            o_cmd.err_we = 1'b1;
                            o_cmd.err    = ERR_STEP;
                        end else begin
                            o_cmd.pos_inc = 1'b1;
                        end
                    end
                    OP_INS_LEFT: begin
                        if (i_sts.full) begin
                            o_cmd.err_we = 1'b1;
                            o_cmd.err    = ERR_FULL;
                        end
                    end
                    OP_INS_RIGHT: begin
                        // A full buffer is reported before the past-end case.
                        if (i_sts.full) begin
                            o_cmd.err_we = 1'b1;
                            o_cmd.err    = ERR_FULL;
                        end else if (!i_sts.empty && i_sts.past_end) begin
                            o_cmd.err_we = 1'b1;
                            o_cmd.err    = ERR_INS_RIGHT;
                        end
                    end
                    OP_ERASE: begin
                        if (i_sts.past_end) begin
                            o_cmd.err_we = 1'b1;
                            o_cmd.err    = ERR_ERASE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                end else if (i_sts.op == OP_ERASE) begin
                    o_cmd.count_dec = 1'b1;
                end
            end
            ST_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            ST_PUT:      o_cmd.put      = 1'b1;
            ST_CAPTURE:  o_cmd.capture  = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/csb_dp.sv =====
// ----------------------------------------------------------------------------
// csb_dp
// Element store, count, cursor position, shift index and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_dp
    import csb_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [OP_W-1:0]       i_op,
    input  wire  [ELEM_BITS-1:0]  i_elem,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ELEM_BITS-1:0]  r_mem [DEPTH];
    logic [ELEM_BITS-1:0]  r_rdata;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_idx;
    t_op                   r_op;
    logic [ELEM_BITS-1:0]  r_elem;
    t_err                  r_err;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  is_erase;
    logic                  empty;
    logic                  past_end;
    logic [CNT_W-1:0]      ins_at;
    logic [CNT_W-1:0]      idx_up;
    logic [CNT_W-1:0]      idx_dn;
    logic [CNT_W-1:0]      rd_idx;
    logic [CNT_W-1:0]      wr_idx;
    logic [ELEM_BITS-1:0]  wr_data;
    logic                  wr_en;
    logic [CUR_W-1:0]      cur_ext;
    logic [LEN_W-1:0]      len_ext;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign is_erase = (r_op == OP_ERASE);
    assign empty    = (r_count == '0);
    assign past_end = (r_pos >= r_count);
    assign idx_up   = r_idx + CNT_W'(1);
    assign idx_dn   = r_idx - CNT_W'(1);

    // Insert right on a non-empty sequence opens the gap after the cursor.
    assign ins_at = ((r_op == OP_INS_RIGHT) && !empty) ? r_pos + CNT_W'(1) : r_pos;

    assign o_sts.op         = r_op;
    assign o_sts.full       = (r_count == CNT_W'(DEPTH));
    assign o_sts.empty      = empty;
    assign o_sts.past_end   = past_end;
    assign o_sts.shift_more = is_erase ? (idx_up < r_count) : (r_idx > ins_at);
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    // Inserts move elements upwards from the end, erases move them down
    // from the cursor; each move is a read beat then a write beat.
    always_comb begin
        if (i_cmd.shift_rd) begin
            rd_idx = is_erase ? idx_up : idx_dn;
        end else begin
            rd_idx = r_pos;
        end
    end

    assign wr_en   = i_cmd.shift_wr || i_cmd.put;
    assign wr_idx  = i_cmd.put ? ins_at : r_idx;
    assign wr_data = i_cmd.put ? r_elem : r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx[ADDR_W-1:0]] <= wr_data;
        end
        r_rdata <= r_mem[rd_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_elem <= i_elem;
            r_err  <= ERR_OK;
            r_idx  <= (t_op'(i_op) == OP_ERASE) ? r_pos : r_count;
        end else begin
            if (i_cmd.err_we) begin
                r_err <= i_cmd.err;
            end
            if (i_cmd.shift_wr) begin
                r_idx <= is_erase ? idx_up : idx_dn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.put) begin
                r_count <= r_count + CNT_W'(1);
                if (r_op == OP_INS_RIGHT) begin
                    r_pos <= ins_at;
                end
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.pos_zero) begin
                r_pos <= '0;
            end else if (i_cmd.pos_inc) begin
                r_pos <= r_pos + CNT_W'(1);
            end
        end
    end

    generate
        if (ELEM_BITS >= CUR_W) begin : g_cur_trunc
            assign cur_ext = r_rdata[CUR_W-1:0];
        end else begin : g_cur_ext
            assign cur_ext = {{(CUR_W - ELEM_BITS){1'b0}}, r_rdata};
        end
        if (CNT_W >= LEN_W) begin : g_len_trunc
            assign len_ext = r_count[LEN_W-1:0];
        end else begin : g_len_ext
            assign len_ext = {{(LEN_W - CNT_W){1'b0}}, r_count};
        end
    endgenerate

    always_comb begin
        n_out_data = '0;
        n_out_data[OUT_CUR_LSB +: CUR_W] = past_end ? '0 : cur_ext;
        n_out_data[OUT_START_BIT]        = (r_pos == '0);
        n_out_data[OUT_STOP_BIT]         = past_end;
        n_out_data[OUT_LEN_LSB +: LEN_W] = len_ext;
        n_out_data[OUT_ERR_LSB +: ERR_W] = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/cursor_sequence_buffer.sv =====
// Each accepted command passes through decide, then, for an insert or erase that
// is not refused, its element moves and, for an insert, the put, then fetch and
// capture into the output register. One command is taken at a time; each element
// move is a read then a write, with up to DEPTH - 1 moves per command.
// A stalled result holds the next command in capture, and none after it is taken.
// Synchronous active-low reset empties the sequence and rewinds the cursor, not the store.
// ----------------------------------------------------------------------------
// cursor_sequence_buffer
// Ordered element sequence with a cursor, edited by insert and erase commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_sequence_buffer
    import csb_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // elem
    input  wire  [((ELEM_BITS + 7) / 8) * 8-1:0] i_s_tdata,
    // operation
    input  wire  [OP_W-1:0]                    i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // cursor_elem[7:0], at_start[8], at_stop[9], length[16:10], error[19:17]
    output logic [OUT_DATA_W-1:0]              o_m_tdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    csb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    csb_dp #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (i_s_tuser),
        .i_elem     (i_s_tdata[ELEM_BITS-1:0]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/csb_checker.sv =====
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks on the result beats of the cursor sequence buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_checker
    import csb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_m_tvalid,
    input wire                  i_m_tready,
    input wire [OUT_DATA_W-1:0] o_m_tdata
);

    logic [CUR_W-1:0] cur;
    logic             at_start;
    logic             at_stop;
    logic [LEN_W-1:0] len;
    logic [ERR_W-1:0] err;

    assign cur      = o_m_tdata[OUT_CUR_LSB +: CUR_W];
    assign at_start = o_m_tdata[OUT_START_BIT];
    assign at_stop  = o_m_tdata[OUT_STOP_BIT];
    assign len      = o_m_tdata[OUT_LEN_LSB +: LEN_W];
    assign err      = o_m_tdata[OUT_ERR_LSB +: ERR_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_stop_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && at_stop |-> cur == '0)
        else $error("cursor element not zero past the end");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && len == '0 |-> at_start && at_stop)
        else $error("empty sequence without cursor at start and stop");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (DEPTH > 127) || (32'(len) <= DEPTH))
        else $error("length beyond capacity");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> err == ERR_OK || err == ERR_STEP || err == ERR_FULL ||
                       err == ERR_ERASE || err == ERR_INS_RIGHT)
        else $error("unknown error code");

endmodule

bind cursor_sequence_buffer csb_checker #(
    .DEPTH (DEPTH)
) u_csb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cursor_sequence_buffer. Edit commands are streamed
// in random bursts. A built-in model of the sequence and its cursor predicts
// each result beat. A monitor compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import csb_pkg::*;

    localparam int SEQ_DEPTH  = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 150;

    // Operation codes with no command of their own; they behave as a read.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      elem;
    } t_edit_cmd;

    typedef struct {
        logic [CUR_W-1:0] cur;
        logic             start;
        logic             stop;
        logic [LEN_W-1:0] len;
        t_err             err;
    } t_cursor_report;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    cursor_sequence_buffer #(
        .DEPTH     (SEQ_DEPTH),
        .ELEM_BITS (8)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Model of the sequence, its length and the cursor.
    logic [7:0]     seq_cells [SEQ_DEPTH];
    int             seq_len = 0;
    int             seq_pos = 0;

    t_edit_cmd      edit_queue [$];
    t_cursor_report pending_reports [$];
    int             edits_total = 0;
    int             edits_taken = 0;
    int             fail_count = 0;

    function automatic void open_slot(int at, logic [7:0] value);
        for (int i = seq_len; i > at; i--) seq_cells[i] = seq_cells[i-1];
        seq_cells[at] = value;
        seq_len++;
    endfunction

    function automatic t_cursor_report apply_edit(logic [OP_W-1:0] op, logic [7:0] value);
        t_cursor_report r;
        r.err = ERR_OK;
        case (op)
            OP_REWIND: seq_pos = 0;
            OP_STEP: begin
                if (seq_pos >= seq_len) r.err = ERR_STEP;
                else seq_pos++;
            end
            OP_INS_LEFT: begin
                if (seq_len >= SEQ_DEPTH) r.err = ERR_FULL;
                else open_slot(seq_pos, value);
            end
            OP_INS_RIGHT: begin
                if (seq_len >= SEQ_DEPTH) begin
                    r.err = ERR_FULL;
                end else if (seq_len == 0) begin
                    seq_pos = 0;
                    open_slot(0, value);
                end else if (seq_pos >= seq_len) begin
                    r.err = ERR_INS_RIGHT;
                end else begin
                    open_slot(seq_pos + 1, value);
                    seq_pos++;
                end
            end
            OP_ERASE: begin
                if (seq_pos >= seq_len) begin
                    r.err = ERR_ERASE;
                end else begin
                    for (int i = seq_pos; i + 1 < seq_len; i++) seq_cells[i] = seq_cells[i+1];
                    seq_len--;
                end
            end
            default: ;
        endcase
        r.cur   = (seq_pos < seq_len) ? seq_cells[seq_pos] : '0;
        r.start = (seq_pos == 0);
        r.stop  = (seq_pos >= seq_len);
        r.len   = seq_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic queue_edit(logic [OP_W-1:0] op, logic [7:0] value);
        t_edit_cmd c;
        c.op   = op;
        c.elem = value;
        edit_queue.push_back(c);
        edits_total++;
    endtask

    // Random operation, weighted towards steps and inserts so the sequence grows.
    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return OP_STEP;
        if (roll < 45) return OP_INS_LEFT;
        if (roll < 65) return OP_INS_RIGHT;
        if (roll < 80) return OP_ERASE;
        if (roll < 88) return OP_REWIND;
        if (roll < 96) return OP_READ;
        return ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    endfunction

    // Sender: bursts of beats separated by random gaps.
    logic      in_fired = 1'b0;
    t_edit_cmd next_cmd;
    int        burst_left = 4;
    int        gap_left = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fired) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (edit_queue.size() > 0) begin
                next_cmd = edit_queue.pop_front();
                s_tuser  <= next_cmd.op;
                s_tdata  <= next_cmd.elem;
                s_tvalid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready probability is redrawn from 100, 80, 50 and 20 percent, with one long hold-off
    // while the sender keeps offering beats.
    int rx_cycles = 0;
    int hold_left = 0;
    int ready_pct = 100;

    always @(negedge clk) begin
        rx_cycles = rx_cycles + 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_cycles == 2500) begin
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            if (rx_cycles % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 80;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
            end
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Monitor: predicts on every accepted command and checks every result beat.
    t_cursor_report got_pred;
    t_cursor_report want;

    always @(posedge clk) begin
        in_fired = s_tvalid && s_tready;
        if (rst_n) begin
            if (in_fired) begin
                got_pred = apply_edit(s_tuser, s_tdata);
                pending_reports.push_back(got_pred);
                edits_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("result beat with no command outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[OUT_CUR_LSB +: CUR_W] !== want.cur) begin
                        $error("cursor_elem: expected %0d, got %0d", want.cur,
                               m_tdata[OUT_CUR_LSB +: CUR_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_START_BIT] !== want.start) begin
                        $error("at_start: expected %0d, got %0d", want.start,
                               m_tdata[OUT_START_BIT]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_STOP_BIT] !== want.stop) begin
                        $error("at_stop: expected %0d, got %0d", want.stop,
                               m_tdata[OUT_STOP_BIT]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_LEN_LSB +: LEN_W] !== want.len) begin
                        $error("length: expected %0d, got %0d", want.len,
                               m_tdata[OUT_LEN_LSB +: LEN_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_ERR_LSB +: ERR_W] !== want.err) begin
                        $error("error: expected %0d, got %0d", want.err,
                               m_tdata[OUT_ERR_LSB +: ERR_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("cursor_sequence_buffer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    int kind;
    int seg_len;

    initial begin
        // Directed: empty-sequence errors, insert right on empty and past the end,
        // append, insert at the front, erase of the first and of the only element,
        // and the two unused operation codes.
        queue_edit(OP_READ, 8'hFF);
        queue_edit(OP_STEP, 8'h00);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_INS_RIGHT, 8'h00);
        queue_edit(OP_STEP, 8'h00);
        queue_edit(OP_INS_RIGHT, 8'h11);
        queue_edit(OP_INS_LEFT, 8'hFF);
        queue_edit(OP_REWIND, 8'h00);
        queue_edit(OP_INS_LEFT, 8'hA5);
        queue_edit(OP_STEP, 8'h00);
        queue_edit(OP_INS_RIGHT, 8'h5A);
        queue_edit(OP_READ, 8'h00);
        queue_edit(OP_SPARE_LO, 8'hFF);
        queue_edit(OP_SPARE_HI, 8'h80);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_REWIND, 8'h00);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_STEP, 8'h00);
        queue_edit(OP_STEP, 8'h00);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_REWIND, 8'h00);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_ERASE, 8'h00);
        queue_edit(OP_STEP, 8'h00);

        // Random: fills that run into the full buffer, drains that erase from the front, and
        // mixed editing in between.
        while (edits_total < 650) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                seg_len = $urandom_range(60, 80);
                for (int i = 0; i < seg_len; i++) begin
                    case ($urandom_range(0, 9))
                        0: queue_edit(OP_STEP, 8'($urandom_range(0, 255)));
                        1, 2, 3: queue_edit(OP_INS_RIGHT, 8'($urandom_range(0, 255)));
                        default: queue_edit(OP_INS_LEFT, 8'($urandom_range(0, 255)));
                    endcase
                end
                for (int i = 0; i < $urandom_range(0, 3); i++) queue_edit(OP_STEP, 8'h00);
                queue_edit(OP_INS_RIGHT, 8'($urandom_range(0, 255)));
                queue_edit(OP_INS_LEFT, 8'($urandom_range(0, 255)));
            end else if (kind < 6) begin
                queue_edit(OP_REWIND, 8'($urandom_range(0, 255)));
                seg_len = $urandom_range(50, 70);
                for (int i = 0; i < seg_len; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_edit(OP_STEP, 8'($urandom_range(0, 255)));
                    end else begin
                        queue_edit(OP_ERASE, 8'($urandom_range(0, 255)));
                    end
                end
            end else begin
                seg_len = $urandom_range(20, 50);
                for (int i = 0; i < seg_len; i++) queue_edit(pick_op(), 8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (edits_taken < edits_total || pending_reports.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (fail_count == 0) begin
            $display("cursor_sequence_buffer: match");
        end else begin
            $display("cursor_sequence_buffer: mismatch");
        end
        $finish;
    end

endmodule
